/* sv/aea_pkg.sv */
// shared types, constants and table function for the auto exposure block
package aea_pkg;

    // register indexes of the configuration port
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_EXPOSURE_ENABLE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_EXPOSURE     = 4'd1;

    // field widths
    localparam int DATA_W  = 16;
    localparam int ENTRY_W = 17;

    // exposure after reset, 2.0 in q4.12
    localparam logic [DATA_W-1:0] RESET_EXPOSURE = 16'd8192;
    // 10.0 in q4.12
    localparam logic [DATA_W-1:0] MAX_TARGET     = 16'd40960;
    localparam logic [17:0]       ONE_Q12        = 18'd4096;

    // rec.709 weights, q0.16, summing to 1.0
    localparam logic [DATA_W-1:0] W_RED   = 16'd13933;
    localparam logic [DATA_W-1:0] W_GREEN = 16'd46871;
    localparam logic [DATA_W-1:0] W_BLUE  = 16'd4732;

    // digit-serial multiplier geometry
    localparam int DIGIT_W    = 4;
    localparam int MAC_DIGITS = DATA_W / DIGIT_W;
    localparam int CNT_W      = $clog2(MAC_DIGITS);
    localparam int MCAND_W    = ENTRY_W + DATA_W - DIGIT_W;
    localparam int ACC_W      = 34;

    // rounding offsets preloaded into the accumulator
    localparam logic [ACC_W-1:0] RND_16 = 34'd32768;
    localparam logic [ACC_W-1:0] RND_17 = 34'd65536;
    localparam logic [ACC_W-1:0] RND_12 = 34'd2048;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LUM_R,
        ST_LUM_R_W,
        ST_LUM_G,
        ST_LUM_G_W,
        ST_LUM_B,
        ST_LUM_B_W,
        ST_BASE,
        ST_RD_A,
        ST_RD_B,
        ST_INTERP,
        ST_INTERP_W,
        ST_TARGET,
        ST_UPDATE,
        ST_UPDATE_W,
        ST_OUT
    } aea_state_t;

    typedef struct packed {
        logic                 start;
        logic                 clear;
        logic [ENTRY_W-1:0]   mcand;
        logic [DATA_W-1:0]    mplier;
        logic [ACC_W-1:0]     acc_init;
    } mac_cmd_t;

    // one table point of t^2.2, t and result in q0.16 (elaboration only)
    function automatic logic [ENTRY_W-1:0] pow_entry(input logic [ENTRY_W-1:0] t);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned a;
        longint unsigned t64;
        longint unsigned t2;
        t64 = 64'(t);
        lo  = 0;
        hi  = 65536;
        for (int it = 0; it < 18; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                a   = mid;
                for (int j = 0; j < 4; j++) begin
                    a = (a * mid + 32768) >> 16;
                end
                if (a <= t64) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        t2 = (t64 * t64 + 32768) >> 16;
        return ENTRY_W'((t2 * lo + 32768) >> 16);
    endfunction

endpackage

/* sv/aea_mac.sv */
// radix-16 digit-serial multiply-accumulate unit
module aea_mac import aea_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  mac_cmd_t         mac_cmd,
    output logic             mac_done,
    output logic [ACC_W-1:0] mac_acc
);

    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(MAC_DIGITS - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MCAND_W-1:0] mcand_reg;
    logic [DATA_W-1:0]  mplier_reg;
    logic [ACC_W-1:0]   acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (mac_cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_DIGIT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // multiplicand walks left one digit per cycle, multiplier walks right
    always_ff @(posedge aclk) begin
        if (mac_cmd.start) begin
            mcand_reg  <= MCAND_W'(mac_cmd.mcand);
            mplier_reg <= mac_cmd.mplier;
            if (mac_cmd.clear) begin
                acc_reg <= mac_cmd.acc_init;
            end
        end else if (busy_reg) begin
            acc_reg    <= acc_reg + ACC_W'(mcand_reg) * ACC_W'(mplier_reg[DIGIT_W-1:0]);
            mcand_reg  <= mcand_reg << DIGIT_W;
            mplier_reg <= mplier_reg >> DIGIT_W;
        end
    end

    assign mac_done = done_reg;
    assign mac_acc  = acc_reg;

endmodule

/* sv/auto_exposure_adaptation.sv */
// auto exposure eye adaptation: top level with sequencer, power table and exposure state
//
// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      s_avg_red/green/blue, s_frame_seconds,
//                                             s_history_present
// m_        out        m_valid / m_ready      m_exposure_out
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an adapting frame runs five 16-bit products through the shared 4-bit digit-serial
// multiplier, with table reads and the base, target and output steps, before its
// result is registered. a frame that does not adapt goes from idle to the output step.
// reset is synchronous, active low; it clears control state, sets the exposure to 2.0
// and arms the first-frame flag. the result sits in an output register, so a stalled
// m_ready only holds the block once the next result is ready.
module auto_exposure_adaptation import aea_pkg::*; #(
    parameter int POW_TABLE_ENTRIES = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input items
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [DATA_W-1:0]      s_avg_red,
    input  logic [DATA_W-1:0]      s_avg_green,
    input  logic [DATA_W-1:0]      s_avg_blue,
    input  logic [DATA_W-1:0]      s_frame_seconds,
    input  logic                   s_history_present,
    // result items
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [DATA_W-1:0]      m_exposure_out,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

    // table index covers 0..POW_TABLE_ENTRIES
    localparam int IDX_W = $clog2(POW_TABLE_ENTRIES + 1);
    localparam int P_W   = 12 + IDX_W;
    localparam logic [P_W-1:0]   N_P   = P_W'(POW_TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_N = IDX_W'(POW_TABLE_ENTRIES);

    // ---------------------------------------------------------------
    // power table, t^2.2 at POW_TABLE_ENTRIES+1 evenly spaced points
    // ---------------------------------------------------------------
    logic [ENTRY_W-1:0] pow_rom [0:POW_TABLE_ENTRIES];

    for (genvar gi = 0; gi <= POW_TABLE_ENTRIES; gi++) begin : g_rom
        localparam logic [ENTRY_W-1:0] T_POINT =
            ENTRY_W'((longint'(gi) * 65536) / POW_TABLE_ENTRIES);
        localparam logic [ENTRY_W-1:0] ENTRY = pow_entry(T_POINT);
        assign pow_rom[gi] = ENTRY;
    end

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    aea_state_t         state_reg;
    aea_state_t         state_next;

    logic               enable_reg;
    logic               first_frame_reg;
    logic [DATA_W-1:0]  exposure_level_reg;

    logic [DATA_W-1:0]  red_reg;
    logic [DATA_W-1:0]  green_reg;
    logic [DATA_W-1:0]  blue_reg;
    logic [DATA_W-1:0]  dt_reg;

    logic [IDX_W-1:0]   k_reg;
    logic [11:0]        f_reg;
    logic [ENTRY_W-1:0] rom_q_reg;
    logic [ENTRY_W-1:0] a_reg;
    logic [DATA_W-1:0]  target_reg;
    logic               lower_reg;

    logic               m_valid_reg;
    logic [DATA_W-1:0]  m_exposure_out_reg;

    // shared multiplier
    mac_cmd_t           mac_cmd;
    logic               mac_done;
    logic [ACC_W-1:0]   mac_acc;

    aea_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mac_cmd  (mac_cmd),
        .mac_done (mac_done),
        .mac_acc  (mac_acc)
    );

    logic in_fire;
    logic adapt_frame;
    logic out_free;

    assign in_fire     = s_valid && s_ready;
    // adaptation runs only with history and after the first enabled frame
    assign adapt_frame = enable_reg && s_history_present && !first_frame_reg;
    assign out_free    = !m_valid_reg || m_ready;

    // ---------------------------------------------------------------
    // datapath helpers
    // ---------------------------------------------------------------
    // luminance in q4.12, then base 1-L clipped at zero, q1.12
    logic [17:0]        lum;
    logic [12:0]        base_x;
    logic [P_W-1:0]     base_p;
    logic [IDX_W-1:0]   k_hi;
    logic [IDX_W-1:0]   rd_idx;

    assign lum    = mac_acc[33:16];
    assign base_x = (lum < ONE_Q12) ? 13'(ONE_Q12 - lum) : 13'd0;
    assign base_p = P_W'(base_x) * N_P;
    // upper interpolation point, held at the last entry at the top end
    assign k_hi   = (k_reg == IDX_N) ? k_reg : k_reg + 1'b1;
    assign rd_idx = (state_reg == ST_RD_A) ? k_reg : k_hi;

    // interpolated power and target exposure, clamped at 10.0
    logic [ENTRY_W:0]   y_sum;
    logic [ENTRY_W-1:0] y_val;
    logic [20:0]        y_x10;
    logic [16:0]        target_raw;
    logic [DATA_W-1:0]  target_val;

    assign y_sum      = (ENTRY_W + 1)'(a_reg) + mac_acc[29:12];
    assign y_val      = y_sum[ENTRY_W-1:0];
    assign y_x10      = {y_val, 3'b000} + {2'b00, y_val, 1'b0} + 21'd8;
    assign target_raw = y_x10[20:4];
    assign target_val = (target_raw > 17'(MAX_TARGET)) ? MAX_TARGET : target_raw[15:0];

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = adapt_frame ? ST_LUM_R : ST_OUT;
                end
            end
            ST_LUM_R:    state_next = ST_LUM_R_W;
            ST_LUM_R_W:  if (mac_done) state_next = ST_LUM_G;
            ST_LUM_G:    state_next = ST_LUM_G_W;
            ST_LUM_G_W:  if (mac_done) state_next = ST_LUM_B;
            ST_LUM_B:    state_next = ST_LUM_B_W;
            ST_LUM_B_W:  if (mac_done) state_next = ST_BASE;
            ST_BASE:     state_next = ST_RD_A;
            ST_RD_A:     state_next = ST_RD_B;
            ST_RD_B:     state_next = ST_INTERP;
            ST_INTERP:   state_next = ST_INTERP_W;
            ST_INTERP_W: if (mac_done) state_next = ST_TARGET;
            ST_TARGET:   state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_UPDATE_W;
            ST_UPDATE_W: if (mac_done) state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs, multiplier commands per step
    // ---------------------------------------------------------------
    always_comb begin
        s_ready          = 1'b0;
        mac_cmd.start    = 1'b0;
        mac_cmd.clear    = 1'b0;
        mac_cmd.mcand    = '0;
        mac_cmd.mplier   = '0;
        mac_cmd.acc_init = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            // weighted color sum, rounding added once at the start
            ST_LUM_R: begin
                mac_cmd.start    = 1'b1;
                mac_cmd.clear    = 1'b1;
                mac_cmd.mcand    = ENTRY_W'(W_RED);
                mac_cmd.mplier   = red_reg;
                mac_cmd.acc_init = RND_16;
            end
            ST_LUM_G: begin
                mac_cmd.start  = 1'b1;
                mac_cmd.mcand  = ENTRY_W'(W_GREEN);
                mac_cmd.mplier = green_reg;
            end
            ST_LUM_B: begin
                mac_cmd.start  = 1'b1;
                mac_cmd.mcand  = ENTRY_W'(W_BLUE);
                mac_cmd.mplier = blue_reg;
            end
            // (upper - lower) * fraction, table is nondecreasing
            ST_INTERP: begin
                mac_cmd.start    = 1'b1;
                mac_cmd.clear    = 1'b1;
                mac_cmd.mcand    = rom_q_reg - a_reg;
                mac_cmd.mplier   = DATA_W'(f_reg);
                mac_cmd.acc_init = RND_12;
            end
            // |target - exposure| * dt, rate halved toward a brighter target
            ST_UPDATE: begin
                mac_cmd.start    = 1'b1;
                mac_cmd.clear    = 1'b1;
                mac_cmd.mcand    = lower_reg ? ENTRY_W'(exposure_level_reg - target_reg)
                                             : ENTRY_W'(target_reg - exposure_level_reg);
                mac_cmd.mplier   = dt_reg;
                mac_cmd.acc_init = lower_reg ? RND_16 : RND_17;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            enable_reg         <= 1'b0;
            first_frame_reg    <= 1'b1;
            exposure_level_reg <= RESET_EXPOSURE;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;

            // a frame with adaptation enabled but not adapting only drops the flag
            if (in_fire && enable_reg && !adapt_frame) begin
                first_frame_reg <= 1'b0;
            end

            if (state_reg == ST_UPDATE_W && mac_done) begin
                if (lower_reg) begin
                    exposure_level_reg <= exposure_level_reg - mac_acc[31:16];
                end else begin
                    exposure_level_reg <= exposure_level_reg + mac_acc[32:17];
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_AUTO_EXPOSURE_ENABLE: enable_reg         <= cfg_data[0];
                    CFG_INITIAL_EXPOSURE:     exposure_level_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end

            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            red_reg   <= s_avg_red;
            green_reg <= s_avg_green;
            blue_reg  <= s_avg_blue;
            dt_reg    <= s_frame_seconds;
        end
        // table position: integer part picks the segment, low 12 bits interpolate
        if (state_reg == ST_BASE) begin
            k_reg <= base_p[P_W-1:12];
            f_reg <= base_p[11:0];
        end
        if (state_reg == ST_RD_A || state_reg == ST_RD_B) begin
            rom_q_reg <= pow_rom[rd_idx];
        end
        if (state_reg == ST_RD_B) begin
            a_reg <= rom_q_reg;
        end
        if (state_reg == ST_TARGET) begin
            target_reg <= target_val;
            lower_reg  <= target_val < exposure_level_reg;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_exposure_out_reg <= exposure_level_reg;
        end
    end

    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_exposure_out = m_exposure_out_reg;

endmodule
